### sv/pbd_pkg.sv
// ----------------------------------------------------------------------------
// Push-button dimmer control package
// Shared types, codes and constants for the dimmer control front, queue and
// back end.
// ----------------------------------------------------------------------------
package pbd_pkg;

  // Input operation codes as they arrive on the stream.
  typedef enum logic [1:0] {
    OP_PIN  = 2'd0,
    OP_TICK = 2'd1,
    OP_LOCK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Commands after classification by the front end.
  typedef enum logic [2:0] {
    CMD_PRESS   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_TICK    = 3'd2,
    CMD_LOCK    = 3'd3,
    CMD_UNLOCK  = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [2:0] chan;
  } cmd_t;

  // Telegram kinds on the result stream.
  typedef enum logic [1:0] {
    TG_SWITCH = 2'd0,
    TG_DIM    = 2'd1,
    TG_STORED = 2'd2,
    TG_NONE   = 2'd3
  } tg_kind_t;

  // Dim modes.
  localparam logic [2:0] MODE_ONE_HAND       = 3'd0;
  localparam logic [2:0] MODE_LIGHTER_ON     = 3'd1;
  localparam logic [2:0] MODE_DARKER_OFF     = 3'd2;
  localparam logic [2:0] MODE_LIGHTER_TOGGLE = 3'd3;
  localparam logic [2:0] MODE_DARKER_TOGGLE  = 3'd4;

  // Lock actions.
  localparam logic [1:0] LOCK_NONE   = 2'd0;
  localparam logic [1:0] LOCK_ON     = 2'd1;
  localparam logic [1:0] LOCK_OFF    = 2'd2;
  localparam logic [1:0] LOCK_TOGGLE = 2'd3;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_DIM_MODE     = 3'd0,
    REG_STOP_SEND    = 3'd1,
    REG_BRIGHTER     = 3'd2,
    REG_DARKER       = 3'd3,
    REG_HOLD_TICKS   = 3'd4,
    REG_REPEAT_TICKS = 3'd5,
    REG_LOCK_ACTION  = 3'd6,
    REG_UNLOCK_OFF   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  dim_mode;
    logic        stop_send_enable;
    logic [2:0]  brighter_step;
    logic [2:0]  darker_step;
    logic [15:0] hold_ticks;
    logic [15:0] repeat_ticks;
    logic [1:0]  lock_action;
    logic        unlock_off_enable;
  } cfg_t;

  localparam logic [3:0] DIR_BIT   = 4'h8;
  localparam logic [3:0] STEP_BITS = 4'h7;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

endpackage

### sv/pbd_front.sv
// ----------------------------------------------------------------------------
// Dimmer control front end
// Accepts input requests, drops those that do nothing and turns the rest into
// commands for the command queue.
// ----------------------------------------------------------------------------
module pbd_front import pbd_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [2:0] in_chan,
  input  logic       in_level,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

  logic      held;
  cmd_t      held_cmd;
  logic      keep;
  cmd_kind_t kind;

  assign in_ready  = !held || cmd_ready;
  assign cmd_valid = held;
  assign cmd       = held_cmd;

  always_comb begin
    keep = ({2'b00, in_chan} < CH_LIMIT);
    kind = CMD_TICK;
    case (op_t'(in_op))
      OP_PIN:  kind = in_level ? CMD_PRESS : CMD_RELEASE;
      OP_TICK: kind = CMD_TICK;
      OP_LOCK: kind = in_level ? CMD_LOCK : CMD_UNLOCK;
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_cmd.kind <= kind;
      held_cmd.chan <= in_chan;
    end
  end

endmodule

### sv/pbd_queue.sv
// ----------------------------------------------------------------------------
// Dimmer control command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pbd_queue import pbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t               entries [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == Q_CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

### sv/pbd_back.sv
// ----------------------------------------------------------------------------
// Dimmer control back end
// Holds the per-channel timers and object values, carries out one command per
// cycle while the output register is not stalled and presents telegrams in it.
// ----------------------------------------------------------------------------
module pbd_back import pbd_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [2:0] res_chan,
  output logic [1:0] res_kind,
  output logic [3:0] res_value
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic        dim_started      [CHANNELS];
  logic [15:0] hold_remaining   [CHANNELS];
  logic        hold_running     [CHANNELS];
  logic [15:0] repeat_remaining [CHANNELS];
  logic        repeat_running   [CHANNELS];
  logic        switch_value     [CHANNELS];
  logic [3:0]  dim_value        [CHANNELS];

  logic [CH_W-1:0] idx;
  logic            fire;

  logic        started_cur, hold_run_cur, rep_run_cur, sw_cur;
  logic [15:0] hold_rem_cur, rep_rem_cur;
  logic [3:0]  dim_cur;

  logic        started_next, hold_run_next, rep_run_next, sw_next;
  logic [15:0] hold_rem_next, rep_rem_next;
  logic [3:0]  dim_next;

  logic        emit;
  tg_kind_t    emit_kind;
  logic [3:0]  emit_value;
  logic        dir;

  assign idx       = CH_W'(cmd.chan);
  assign cmd_ready = !res_valid || res_ready;
  assign fire      = cmd_valid && cmd_ready;

  assign started_cur  = dim_started[idx];
  assign hold_rem_cur = hold_remaining[idx];
  assign hold_run_cur = hold_running[idx];
  assign rep_rem_cur  = repeat_remaining[idx];
  assign rep_run_cur  = repeat_running[idx];
  assign sw_cur       = switch_value[idx];
  assign dim_cur      = dim_value[idx];

  always_comb begin
    started_next  = started_cur;
    hold_rem_next = hold_rem_cur;
    hold_run_next = hold_run_cur;
    rep_rem_next  = rep_rem_cur;
    rep_run_next  = rep_run_cur;
    sw_next       = sw_cur;
    dim_next      = dim_cur;
    emit          = 1'b0;
    emit_kind     = TG_SWITCH;
    emit_value    = 4'h0;

    // Direction taken when dimming starts; unused modes keep the old one.
    case (cfg.dim_mode)
      MODE_ONE_HAND:       dir = !dim_cur[3];
      MODE_LIGHTER_ON:     dir = 1'b1;
      MODE_LIGHTER_TOGGLE: dir = 1'b1;
      MODE_DARKER_OFF:     dir = 1'b0;
      MODE_DARKER_TOGGLE:  dir = 1'b0;
      default:             dir = dim_cur[3];
    endcase

    case (cmd.kind)
      CMD_PRESS: begin
        hold_rem_next = cfg.hold_ticks;
        hold_run_next = 1'b1;
      end
      CMD_RELEASE: begin
        hold_rem_next = 16'd0;
        hold_run_next = 1'b0;
        rep_rem_next  = 16'd0;
        rep_run_next  = 1'b0;
        emit          = 1'b1;
        if (started_cur) begin
          // Step code zero is the stop telegram.
          started_next = 1'b0;
          dim_next     = dim_cur & DIR_BIT;
          emit_kind    = cfg.stop_send_enable ? TG_DIM : TG_STORED;
          emit_value   = dim_cur & DIR_BIT;
        end else begin
          sw_next = !sw_cur;
          if (cfg.dim_mode == MODE_LIGHTER_ON) begin
            sw_next = 1'b1;
          end
          if (cfg.dim_mode == MODE_DARKER_OFF) begin
            sw_next = 1'b0;
          end
          emit_kind  = TG_SWITCH;
          emit_value = {3'b000, sw_next};
        end
      end
      CMD_TICK: begin
        if (hold_run_cur && hold_rem_cur <= 16'd1) begin
          hold_rem_next = 16'd0;
          hold_run_next = 1'b0;
          started_next  = 1'b1;
          dim_next      = {dir, dir ? cfg.brighter_step : cfg.darker_step};
          rep_rem_next  = cfg.repeat_ticks;
          rep_run_next  = (cfg.repeat_ticks != 16'd0);
          emit          = 1'b1;
          emit_kind     = TG_DIM;
          emit_value    = {dir, dir ? cfg.brighter_step : cfg.darker_step};
        end else begin
          if (hold_run_cur) begin
            hold_rem_next = hold_rem_cur - 16'd1;
          end
          if (rep_run_cur) begin
            if (rep_rem_cur <= 16'd1) begin
              rep_rem_next = cfg.repeat_ticks;
              rep_run_next = (cfg.repeat_ticks != 16'd0);
              emit         = 1'b1;
              emit_kind    = TG_DIM;
              emit_value   = dim_cur;
            end else begin
              rep_rem_next = rep_rem_cur - 16'd1;
            end
          end
        end
      end
      CMD_LOCK: begin
        emit      = (cfg.lock_action != LOCK_NONE);
        emit_kind = TG_SWITCH;
        case (cfg.lock_action)
          LOCK_ON:     sw_next = 1'b1;
          LOCK_OFF:    sw_next = 1'b0;
          LOCK_TOGGLE: sw_next = !sw_cur;
          default:     sw_next = sw_cur;
        endcase
        emit_value = {3'b000, sw_next};
      end
      CMD_UNLOCK: begin
        if (cfg.unlock_off_enable) begin
          sw_next    = 1'b0;
          emit       = 1'b1;
          emit_kind  = TG_SWITCH;
          emit_value = 4'h0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        dim_started[i]      <= 1'b0;
        hold_remaining[i]   <= 16'd0;
        hold_running[i]     <= 1'b0;
        repeat_remaining[i] <= 16'd0;
        repeat_running[i]   <= 1'b0;
        switch_value[i]     <= 1'b0;
        dim_value[i]        <= 4'h0;
      end
    end else if (fire) begin
      dim_started[idx]      <= started_next;
      hold_remaining[idx]   <= hold_rem_next;
      hold_running[idx]     <= hold_run_next;
      repeat_remaining[idx] <= rep_rem_next;
      repeat_running[idx]   <= rep_run_next;
      switch_value[idx]     <= sw_next;
      dim_value[idx]        <= dim_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_ready) begin
      res_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_chan  <= cmd.chan;
      res_kind  <= emit_kind;
      res_value <= emit_value;
    end
  end

endmodule

### sv/pushbutton_dimmer_control.sv
// Path: front end holding register, command queue, back end output register.
// Throughput: one request per cycle while the queue is not full; the back end
// updates one channel's registers per cycle while its output register is free
// or being taken, and a four-entry command queue absorbs output stalls.
// Reset: synchronous, clears all channel state and the queue and loads the
// register defaults.
// ----------------------------------------------------------------------------
// Push-button dimmer control
// Switch and dim telegram logic for several push-button channels, with a
// register port for the dim mode, step sizes, timing and lock behaviour.
// ----------------------------------------------------------------------------
module pushbutton_dimmer_control import pbd_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [2:0] chan, [3] level, [7:4] zero
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [2:0] out_chan, [6:3] telegram_value, [7] zero
  output logic [1:0]  m_tuser,   // [1:0] telegram_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  reg_idx_t   reg_idx;
  logic       front_valid;
  logic       q_full;
  logic       q_empty;
  cmd_t       front_cmd;
  cmd_t       q_cmd;
  logic       back_ready;
  logic [2:0] res_chan;
  logic [1:0] res_kind;
  logic [3:0] res_value;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_mode          <= MODE_ONE_HAND;
      cfg.stop_send_enable  <= 1'b1;
      cfg.brighter_step     <= 3'd1;
      cfg.darker_step       <= 3'd1;
      cfg.hold_ticks        <= 16'd50;
      cfg.repeat_ticks      <= 16'd0;
      cfg.lock_action       <= LOCK_NONE;
      cfg.unlock_off_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_DIM_MODE:     cfg.dim_mode          <= pwdata[2:0];
        REG_STOP_SEND:    cfg.stop_send_enable  <= pwdata[0];
        REG_BRIGHTER:     cfg.brighter_step     <= pwdata[2:0];
        REG_DARKER:       cfg.darker_step       <= pwdata[2:0];
        REG_HOLD_TICKS:   cfg.hold_ticks        <= pwdata[15:0];
        REG_REPEAT_TICKS: cfg.repeat_ticks      <= pwdata[15:0];
        REG_LOCK_ACTION:  cfg.lock_action       <= pwdata[1:0];
        REG_UNLOCK_OFF:   cfg.unlock_off_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIM_MODE:     prdata = {29'd0, cfg.dim_mode};
      REG_STOP_SEND:    prdata = {31'd0, cfg.stop_send_enable};
      REG_BRIGHTER:     prdata = {29'd0, cfg.brighter_step};
      REG_DARKER:       prdata = {29'd0, cfg.darker_step};
      REG_HOLD_TICKS:   prdata = {16'd0, cfg.hold_ticks};
      REG_REPEAT_TICKS: prdata = {16'd0, cfg.repeat_ticks};
      REG_LOCK_ACTION:  prdata = {30'd0, cfg.lock_action};
      REG_UNLOCK_OFF:   prdata = {31'd0, cfg.unlock_off_enable};
      default:          prdata = 32'd0;
    endcase
  end

  pbd_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_chan   (s_tdata[2:0]),
    .in_level  (s_tdata[3]),
    .cmd_valid (front_valid),
    .cmd_ready (!q_full),
    .cmd       (front_cmd)
  );

  pbd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .din   (front_cmd),
    .full  (q_full),
    .pop   (back_ready),
    .dout  (q_cmd),
    .empty (q_empty)
  );

  pbd_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (!q_empty),
    .cmd_ready (back_ready),
    .cmd       (q_cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_chan  (res_chan),
    .res_kind  (res_kind),
    .res_value (res_value)
  );

  assign m_tdata = {1'b0, res_value, res_chan};
  assign m_tuser = res_kind;

endmodule
